### rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition implies a consequence in the same cycle.
`define ASSERT_SAME(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Check that a condition implies a consequence in the next cycle.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

### rtl/lcc_pkg.sv
// Package with the opcodes, state type and fixed field widths of the component labeler.
package lcc_pkg;

  localparam int unsigned OpW   = 2;
  localparam int unsigned AddrW = 13;
  localparam int unsigned ValW  = 14;
  localparam int unsigned CntW  = 11;
  localparam int unsigned LblW  = 10;

  localparam logic [OpW-1:0] OP_LOAD_ROW  = 2'd0;
  localparam logic [OpW-1:0] OP_LOAD_EDGE = 2'd1;
  localparam logic [OpW-1:0] OP_RUN       = 2'd2;
  localparam logic [OpW-1:0] OP_QUERY     = 2'd3;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLEAR,
    S_VCHK,
    S_VTEST,
    S_VROW,
    S_END_RD,
    S_END_W,
    S_SCAN,
    S_NB_W,
    S_LB_W,
    S_PUSH_W,
    S_POP_W,
    S_QUERY_W
  } state_e;

endpackage

### rtl/lcc_if.sv
// Valid/ready channel interfaces for command transactions and result transactions.
interface lcc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [12:0] address;
  logic [13:0] value;
  modport source (output valid, output op, output address, output value, input ready);
  modport sink (input valid, input op, input address, input value, output ready);
endinterface

interface lcc_out_if;
  logic        valid;
  logic        ready;
  logic        status;
  logic [10:0] component_count;
  logic [10:0] largest_size;
  logic [9:0]  largest_label;
  logic [9:0]  vertex_label;
  logic        in_largest;
  modport source (output valid, output status, output component_count,
                  output largest_size, output largest_label, output vertex_label,
                  output in_largest, input ready);
  modport sink (input valid, input status, input component_count,
                input largest_size, input largest_label, input vertex_label,
                input in_largest, output ready);
endinterface

### rtl/lcc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lcc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### rtl/largest_connected_component_core.sv
// Top level of the largest connected component labeler.
//
//  channel  dir  handshake    payload
//  in_i     in   valid/ready  op, address, value
//  out_o    out  valid/ready  status, component_count, largest_size, largest_label,
//                             vertex_label, in_largest
//  cfg      in   we only      vertex_count
//
// Loads answer straight from the idle state; a query first waits on one label RAM read.
// A run clears every label entry, then checks each vertex in turn, scans its edge slots,
// pushes and pops the stack and closes each finished root.
// Reset is asynchronous and clears control and summary; stores stay undefined.
// A pending result stalls the next command until out_o is taken.
module largest_connected_component_core #(
  parameter int unsigned MAX_VERTICES = 1024,
  parameter int unsigned MAX_EDGES    = 8192
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [10:0] cfg_wdata_i,
  lcc_in_if.sink      in_i,
  lcc_out_if.source   out_o
);
  import lcc_pkg::*;

  localparam int unsigned VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int unsigned EW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int unsigned RW = $clog2(MAX_VERTICES + 1);
  localparam int unsigned CW = VW + 1;
  localparam int unsigned OW = EW + 1;

  state_e state_q, state_d;

  logic [CntW-1:0] vcount_q;
  logic [VW-1:0]   clr_q, clr_d;
  logic [CW-1:0]   v_q, v_d, n_q, n_d, comp_q, comp_d, csize_q, csize_d;
  logic [CW-1:0]   best_size_q, best_size_d, depth_q, depth_d;
  logic [VW-1:0]   best_lbl_q, best_lbl_d, cur_q, cur_d, nb_q, nb_d;
  logic [OW-1:0]   slot_q, slot_d, end_q, end_d;
  logic [CW-1:0]   sum_count_q, sum_count_d, sum_size_q, sum_size_d;
  logic [VW-1:0]   sum_lbl_q, sum_lbl_d;
  logic            ran_q, ran_d;
  logic            ovalid_q, ovalid_d, ostatus_q, ostatus_d, oinl_q, oinl_d;
  logic [VW-1:0]   olbl_q, olbl_d;

  logic          rs_we;
  logic [RW-1:0] rs_waddr, rs_raddr;
  logic [OW-1:0] rs_wdata, rs_rdata;
  logic          nbr_we;
  logic [EW-1:0] nbr_waddr, nbr_raddr;
  logic [VW-1:0] nbr_wdata, nbr_rdata;
  logic          lb_we;
  logic [VW-1:0] lb_waddr, lb_raddr;
  logic [VW:0]   lb_wdata, lb_rdata;
  logic          stk_we;
  logic [VW-1:0] stk_waddr, stk_raddr;
  logic [VW+OW-1:0] stk_wdata, stk_rdata;

  logic accept;

  lcc_ram #(.Width(OW), .Depth(MAX_VERTICES + 1)) u_row_ram (
    .clk_i, .we_i(rs_we), .waddr_i(rs_waddr), .wdata_i(rs_wdata),
    .raddr_i(rs_raddr), .rdata_o(rs_rdata)
  );

  lcc_ram #(.Width(VW), .Depth(MAX_EDGES)) u_nbr_ram (
    .clk_i, .we_i(nbr_we), .waddr_i(nbr_waddr), .wdata_i(nbr_wdata),
    .raddr_i(nbr_raddr), .rdata_o(nbr_rdata)
  );

  lcc_ram #(.Width(VW + 1), .Depth(MAX_VERTICES)) u_lbl_ram (
    .clk_i, .we_i(lb_we), .waddr_i(lb_waddr), .wdata_i(lb_wdata),
    .raddr_i(lb_raddr), .rdata_o(lb_rdata)
  );

  lcc_ram #(.Width(VW + OW), .Depth(MAX_VERTICES)) u_stk_ram (
    .clk_i, .we_i(stk_we), .waddr_i(stk_waddr), .wdata_i(stk_wdata),
    .raddr_i(stk_raddr), .rdata_o(stk_rdata)
  );

  assign in_i.ready = (state_q == S_IDLE) && (!ovalid_q || out_o.ready);
  assign accept     = in_i.valid && in_i.ready;

  assign out_o.valid           = ovalid_q;
  assign out_o.status          = ostatus_q;
  assign out_o.component_count = CntW'(sum_count_q);
  assign out_o.largest_size    = CntW'(sum_size_q);
  assign out_o.largest_label   = LblW'(sum_lbl_q);
  assign out_o.vertex_label    = LblW'(olbl_q);
  assign out_o.in_largest      = oinl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      vcount_q    <= '0;
      clr_q       <= '0;
      v_q         <= '0;
      n_q         <= '0;
      comp_q      <= '0;
      csize_q     <= '0;
      best_size_q <= '0;
      best_lbl_q  <= '0;
      depth_q     <= '0;
      cur_q       <= '0;
      nb_q        <= '0;
      slot_q      <= '0;
      end_q       <= '0;
      sum_count_q <= '0;
      sum_size_q  <= '0;
      sum_lbl_q   <= '0;
      ran_q       <= 1'b0;
      ovalid_q    <= 1'b0;
      ostatus_q   <= STATUS_OK;
      oinl_q      <= 1'b0;
      olbl_q      <= '0;
    end else begin
      state_q     <= state_d;
      if (cfg_we_i) begin
        vcount_q <= cfg_wdata_i;
      end
      clr_q       <= clr_d;
      v_q         <= v_d;
      n_q         <= n_d;
      comp_q      <= comp_d;
      csize_q     <= csize_d;
      best_size_q <= best_size_d;
      best_lbl_q  <= best_lbl_d;
      depth_q     <= depth_d;
      cur_q       <= cur_d;
      nb_q        <= nb_d;
      slot_q      <= slot_d;
      end_q       <= end_d;
      sum_count_q <= sum_count_d;
      sum_size_q  <= sum_size_d;
      sum_lbl_q   <= sum_lbl_d;
      ran_q       <= ran_d;
      ovalid_q    <= ovalid_d;
      ostatus_q   <= ostatus_d;
      oinl_q      <= oinl_d;
      olbl_q      <= olbl_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    v_d         = v_q;
    n_d         = n_q;
    comp_d      = comp_q;
    csize_d     = csize_q;
    best_size_d = best_size_q;
    best_lbl_d  = best_lbl_q;
    depth_d     = depth_q;
    cur_d       = cur_q;
    nb_d        = nb_q;
    slot_d      = slot_q;
    end_d       = end_q;
    sum_count_d = sum_count_q;
    sum_size_d  = sum_size_q;
    sum_lbl_d   = sum_lbl_q;
    ran_d       = ran_q;
    ovalid_d    = ovalid_q && !out_o.ready;
    ostatus_d   = ostatus_q;
    oinl_d      = oinl_q;
    olbl_d      = olbl_q;

    rs_we     = 1'b0;
    rs_waddr  = RW'(in_i.address);
    rs_wdata  = OW'(in_i.value);
    rs_raddr  = RW'(cur_q) + RW'(1);
    nbr_we    = 1'b0;
    nbr_waddr = EW'(in_i.address);
    nbr_wdata = VW'(in_i.value);
    nbr_raddr = slot_q[EW-1:0];
    lb_we     = 1'b0;
    lb_waddr  = clr_q;
    lb_wdata  = '0;
    lb_raddr  = VW'(in_i.address);
    stk_we    = 1'b0;
    stk_waddr = VW'(depth_q - CW'(1));
    stk_wdata = {cur_q, slot_q};
    stk_raddr = VW'(depth_q - CW'(2));

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          ostatus_d = STATUS_OK;
          oinl_d    = 1'b0;
          olbl_d    = '0;
          unique case (in_i.op)
            OP_LOAD_ROW: begin
              ovalid_d = 1'b1;
              if (int'(in_i.address) > MAX_VERTICES || int'(in_i.value) > MAX_EDGES) begin
                ostatus_d = STATUS_ERR;
              end else begin
                rs_we = 1'b1;
              end
            end
            OP_LOAD_EDGE: begin
              ovalid_d = 1'b1;
              if (int'(in_i.address) >= MAX_EDGES ||
                  int'(in_i.value) >= MAX_VERTICES) begin
                ostatus_d = STATUS_ERR;
              end else begin
                nbr_we = 1'b1;
              end
            end
            OP_RUN: begin
              if (int'(vcount_q) > MAX_VERTICES) begin
                ovalid_d  = 1'b1;
                ostatus_d = STATUS_ERR;
              end else begin
                n_d         = CW'(vcount_q);
                clr_d       = '0;
                v_d         = '0;
                comp_d      = '0;
                best_size_d = '0;
                best_lbl_d  = '0;
                state_d     = S_CLEAR;
              end
            end
            OP_QUERY: begin
              if (int'(in_i.address) < int'(vcount_q) &&
                  int'(in_i.address) < MAX_VERTICES && ran_q) begin
                state_d = S_QUERY_W;
              end else begin
                ovalid_d  = 1'b1;
                ostatus_d = STATUS_ERR;
              end
            end
            default: ;
          endcase
        end
      end
      S_CLEAR: begin
        lb_we = 1'b1;
        clr_d = clr_q + VW'(1);
        if (int'(clr_q) == MAX_VERTICES - 1) begin
          ran_d   = 1'b1;
          state_d = S_VCHK;
        end
      end
      S_VCHK: begin
        lb_raddr = VW'(v_q);
        if (v_q == n_q) begin
          sum_count_d = comp_q;
          sum_size_d  = best_size_q;
          sum_lbl_d   = best_lbl_q;
          ovalid_d    = 1'b1;
          state_d     = S_IDLE;
        end else begin
          state_d = S_VTEST;
        end
      end
      S_VTEST: begin
        rs_raddr = RW'(v_q);
        if (lb_rdata[VW]) begin
          v_d     = v_q + CW'(1);
          state_d = S_VCHK;
        end else begin
          lb_we    = 1'b1;
          lb_waddr = VW'(v_q);
          lb_wdata = {1'b1, VW'(comp_q)};
          state_d  = S_VROW;
        end
      end
      S_VROW: begin
        cur_d   = VW'(v_q);
        slot_d  = rs_rdata;
        depth_d = CW'(1);
        csize_d = CW'(1);
        state_d = S_END_RD;
      end
      S_END_RD: begin
        state_d = S_END_W;
      end
      S_END_W: begin
        end_d   = (int'(rs_rdata) > MAX_EDGES) ? OW'(MAX_EDGES) : rs_rdata;
        state_d = S_SCAN;
      end
      S_SCAN: begin
        if (slot_q < end_q) begin
          slot_d  = slot_q + OW'(1);
          state_d = S_NB_W;
        end else if (depth_q == CW'(1)) begin
          if (csize_q > best_size_q) begin
            best_size_d = csize_q;
            best_lbl_d  = VW'(comp_q);
          end
          comp_d  = comp_q + CW'(1);
          v_d     = v_q + CW'(1);
          state_d = S_VCHK;
        end else begin
          depth_d = depth_q - CW'(1);
          state_d = S_POP_W;
        end
      end
      S_NB_W: begin
        nb_d     = nbr_rdata;
        lb_raddr = nbr_rdata;
        state_d  = (CW'(nbr_rdata) < n_q) ? S_LB_W : S_SCAN;
      end
      S_LB_W: begin
        rs_raddr = RW'(nb_q);
        if (lb_rdata[VW]) begin
          state_d = S_SCAN;
        end else begin
          lb_we    = 1'b1;
          lb_waddr = nb_q;
          lb_wdata = {1'b1, VW'(comp_q)};
          csize_d  = csize_q + CW'(1);
          stk_we   = 1'b1;
          state_d  = S_PUSH_W;
        end
      end
      S_PUSH_W: begin
        cur_d   = nb_q;
        slot_d  = rs_rdata;
        depth_d = depth_q + CW'(1);
        state_d = S_END_RD;
      end
      S_POP_W: begin
        cur_d   = stk_rdata[VW+OW-1:OW];
        slot_d  = stk_rdata[OW-1:0];
        state_d = S_END_RD;
      end
      S_QUERY_W: begin
        ovalid_d = 1'b1;
        if (lb_rdata[VW]) begin
          olbl_d = lb_rdata[VW-1:0];
          oinl_d = (sum_count_q != '0) && (lb_rdata[VW-1:0] == sum_lbl_q);
        end else begin
          ostatus_d = STATUS_ERR;
        end
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

### rtl/lcc_checker.sv
// Port checker for the component labeler and its bind to the top level.
`include "assert_macros.svh"

module lcc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic        status_i,
  input logic [10:0] component_count_i,
  input logic [10:0] largest_size_i,
  input logic [9:0]  largest_label_i,
  input logic [9:0]  vertex_label_i,
  input logic        in_largest_i
);

  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i)
  `ASSERT_NEXT(a_accept_response, clk_i, rst_ni, in_valid_i && in_ready_i,
               out_valid_i || !in_ready_i)
  `ASSERT_SAME(a_in_largest_label, clk_i, rst_ni, out_valid_i && in_largest_i,
               vertex_label_i == largest_label_i && status_i == 1'b0)
  `ASSERT_SAME(a_empty_summary, clk_i, rst_ni, out_valid_i && component_count_i == 11'd0,
               largest_size_i == 11'd0 && in_largest_i == 1'b0)

endmodule

bind largest_connected_component_core lcc_checker u_lcc_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_i.valid),
  .in_ready_i        (in_i.ready),
  .out_valid_i       (out_o.valid),
  .out_ready_i       (out_o.ready),
  .status_i          (out_o.status),
  .component_count_i (out_o.component_count),
  .largest_size_i    (out_o.largest_size),
  .largest_label_i   (out_o.largest_label),
  .vertex_label_i    (out_o.vertex_label),
  .in_largest_i      (out_o.in_largest)
);

### tb/sv/tb.sv
// Testbench for the largest connected component labeler: directed, full graph, backpressure and random graphs.
`timescale 1ns / 1ps
module tb;
  import lcc_pkg::*;

  localparam int NV = 1024;
  localparam int NE = 8192;
  localparam int LIMIT = 3000000;

  typedef struct packed {
    logic       status;
    logic [10:0] count;
    logic [10:0] lsize;
    logic [9:0]  llabel;
    logic [9:0]  vlabel;
    logic        inl;
  } summary_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [10:0] cfg_wdata_i = '0;

  lcc_in_if in_if ();
  lcc_out_if out_if ();

  largest_connected_component_core u_top (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .in_i(in_if), .out_o(out_if)
  );

  int row_mem [0:NV];
  int nbr_mem [0:NE-1];
  int lbl_mem [0:NV-1];
  bit lbl_ok [0:NV-1];
  int sizes [0:NV-1];
  int vstk [0:NV-1];
  int ostk [0:NV-1];
  int vcount, comp_total, big_size, big_label;
  summary_t pending_q [$];
  int errors, cycles, items;
  bit send_burst, recv_burst, hold_req;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  initial begin
    in_if.valid = 1'b0;
    in_if.op = '0;
    in_if.address = '0;
    in_if.value = '0;
    out_if.ready = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  function automatic void label_graph(int n);
    int comp, depth, cur, slot, stop, nb;
    bit pushed;
    comp = 0;
    for (int i = 0; i < NV; i++) begin
      lbl_ok[i] = 0;
      lbl_mem[i] = 0;
      sizes[i] = 0;
    end
    for (int v = 0; v < n; v++) begin
      if (lbl_ok[v]) continue;
      lbl_ok[v] = 1;
      lbl_mem[v] = comp;
      vstk[0] = v;
      ostk[0] = row_mem[v];
      depth = 1;
      while (depth > 0) begin
        cur = vstk[depth-1];
        slot = ostk[depth-1];
        stop = row_mem[cur+1];
        pushed = 0;
        if (stop > NE) stop = NE;
        while (slot < stop) begin
          nb = nbr_mem[slot];
          slot++;
          if (nb < n && !lbl_ok[nb]) begin
            lbl_ok[nb] = 1;
            lbl_mem[nb] = comp;
            ostk[depth-1] = slot;
            if (depth < NV) begin
              vstk[depth] = nb;
              ostk[depth] = row_mem[nb];
              depth++;
            end
            pushed = 1;
            break;
          end
        end
        if (!pushed) depth--;
      end
      comp++;
    end
    for (int i = 0; i < n; i++) sizes[lbl_mem[i]]++;
    comp_total = comp;
    big_size = 0;
    big_label = 0;
    for (int i = 0; i < comp; i++) begin
      if (sizes[i] > big_size) begin
        big_size = sizes[i];
        big_label = i;
      end
    end
  endfunction

  function automatic summary_t apply_command(logic [1:0] op, int addr, int val);
    summary_t r;
    int lbl;
    r = '0;
    case (op)
      OP_LOAD_ROW: begin
        if (addr > NV || val > NE) r.status = STATUS_ERR;
        else row_mem[addr] = val;
      end
      OP_LOAD_EDGE: begin
        if (addr >= NE || val >= NV) r.status = STATUS_ERR;
        else nbr_mem[addr] = val;
      end
      OP_RUN: begin
        if (vcount > NV) r.status = STATUS_ERR;
        else label_graph(vcount);
      end
      default: begin
        if (addr >= vcount || addr >= NV || !lbl_ok[addr]) begin
          r.status = STATUS_ERR;
        end else begin
          lbl = lbl_mem[addr];
          r.vlabel = lbl[9:0];
          r.inl = (comp_total > 0 && lbl == big_label);
        end
      end
    endcase
    r.count = comp_total[10:0];
    r.lsize = big_size[10:0];
    r.llabel = big_label[9:0];
    return r;
  endfunction

  task automatic send_cmd(logic [1:0] op, int addr, int val);
    int gap;
    gap = send_burst ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.op <= op;
    in_if.address <= addr[12:0];
    in_if.value <= val[13:0];
    do @(posedge clk_i); while (!in_if.ready);
    pending_q.insert(pending_q.size(), apply_command(op, addr, val));
    items++;
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    while (pending_q.size() > 0) @(posedge clk_i);
  endtask

  task automatic set_vertices(int n);
    drain();
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= n[10:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    vcount = n;
  endtask

  task automatic report(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d", what, got, want);
    errors++;
  endtask

  initial begin
    summary_t e;
    int stall;
    forever begin
      if (hold_req) begin
        hold_req = 0;
        out_if.ready <= 1'b0;
        repeat (400) @(posedge clk_i);
      end
      stall = recv_burst ? 0 : $urandom_range(0, 16);
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (!out_if.valid);
      if (pending_q.size() == 0) begin
        report("unexpected transaction", 1, 0);
      end else begin
        e = pending_q.pop_front();
        if (out_if.status !== e.status) report("status", out_if.status, e.status);
        if (out_if.component_count !== e.count)
          report("component_count", out_if.component_count, e.count);
        if (out_if.largest_size !== e.lsize)
          report("largest_size", out_if.largest_size, e.lsize);
        if (out_if.largest_label !== e.llabel)
          report("largest_label", out_if.largest_label, e.llabel);
        if (out_if.vertex_label !== e.vlabel)
          report("vertex_label", out_if.vertex_label, e.vlabel);
        if (out_if.in_largest !== e.inl) report("in_largest", out_if.in_largest, e.inl);
      end
    end
  end

  task automatic test_directed();
    send_cmd(OP_QUERY, 0, 0);
    set_vertices(2);
    send_cmd(OP_LOAD_ROW, 0, 8190);
    send_cmd(OP_LOAD_ROW, 1, 8191);
    send_cmd(OP_LOAD_ROW, 2, 8192);
    send_cmd(OP_LOAD_EDGE, 8190, 1);
    send_cmd(OP_LOAD_EDGE, 8191, 0);
    send_cmd(OP_RUN, 8191, 16383);
    send_cmd(OP_QUERY, 0, 16383);
    send_cmd(OP_QUERY, 1, 0);
    send_cmd(OP_QUERY, 2, 0);
    send_cmd(OP_QUERY, 8191, 0);
    send_cmd(OP_LOAD_ROW, 1025, 0);
    send_cmd(OP_LOAD_ROW, 8191, 16383);
    send_cmd(OP_LOAD_ROW, 3, 8193);
    send_cmd(OP_LOAD_EDGE, 5, 1024);
    send_cmd(OP_LOAD_EDGE, 8191, 16383);
    set_vertices(2047);
    send_cmd(OP_RUN, 0, 0);
    send_cmd(OP_QUERY, 1, 0);
    set_vertices(0);
    send_cmd(OP_LOAD_ROW, 0, 0);
    send_cmd(OP_RUN, 0, 0);
    send_cmd(OP_QUERY, 0, 0);
  endtask

  task automatic test_full_graph();
    set_vertices(NV);
    send_burst = 1;
    recv_burst = 1;
    for (int v = 0; v <= NV; v++) send_cmd(OP_LOAD_ROW, v, v / 16);
    for (int s = 0; s < NV / 16; s++) send_cmd(OP_LOAD_EDGE, s, $urandom_range(0, NV - 1));
    send_cmd(OP_RUN, 0, 0);
    send_burst = 0;
    recv_burst = 0;
    for (int i = 0; i < 8; i++) send_cmd(OP_QUERY, $urandom_range(0, NV - 1), 0);
    send_cmd(OP_QUERY, NV - 1, 0);
    send_cmd(OP_QUERY, NV, 0);
  endtask

  task automatic noise();
    case ($urandom_range(0, 3))
      0: send_cmd(OP_LOAD_ROW, $urandom_range(1025, 8191), $urandom_range(0, 16383));
      1: send_cmd(OP_LOAD_ROW, $urandom_range(0, 1024), $urandom_range(8193, 16383));
      2: send_cmd(OP_LOAD_EDGE, $urandom_range(0, 8191), $urandom_range(1024, 16383));
      default: send_cmd(OP_QUERY, $urandom_range(0, 8191), $urandom_range(0, 16383));
    endcase
  endtask

  task automatic test_random_graphs();
    int n, top, off;
    while (items < 1350) begin
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 90) : $urandom_range(0, 24);
      send_burst = ($urandom_range(0, 3) == 0);
      recv_burst = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 3) == 0) begin
        set_vertices($urandom_range(0, 1) ? n : $urandom_range(0, 2047));
        for (int i = 0; i < 4; i++) send_cmd(OP_QUERY, $urandom_range(0, n + 2), 0);
      end
      set_vertices(n);
      off = 0;
      top = 0;
      for (int v = 0; v <= n; v++) begin
        if ($urandom_range(0, 9) == 0) off = (off > 3) ? off - $urandom_range(1, 3) : off;
        else off = off + $urandom_range(0, 4);
        if (off > top) top = off;
        send_cmd(OP_LOAD_ROW, v, off);
        if ($urandom_range(0, 9) == 0) noise();
      end
      for (int s = 0; s < top; s++) begin
        send_cmd(OP_LOAD_EDGE, s, ($urandom_range(0, 15) == 0) ?
                 $urandom_range(0, NV - 1) : $urandom_range(0, n + 3));
        if ($urandom_range(0, 9) == 0) noise();
      end
      if ($urandom_range(0, 15) == 0) set_vertices($urandom_range(1025, 2047));
      send_cmd(OP_RUN, $urandom_range(0, 8191), $urandom_range(0, 16383));
      for (int i = 0; i < n + 3; i++) send_cmd(OP_QUERY, $urandom_range(0, n + 2), 0);
      noise();
    end
  endtask

  task automatic test_backpressure();
    set_vertices(vcount);
    send_burst = 1;
    hold_req = 1;
    for (int i = 0; i < 40; i++) send_cmd(OP_QUERY, $urandom_range(0, 40), 0);
    send_burst = 0;
  endtask

  initial begin
    errors = 0;
    cycles = 0;
    items = 0;
    vcount = 0;
    comp_total = 0;
    big_size = 0;
    big_label = 0;
    send_burst = 0;
    recv_burst = 0;
    hold_req = 0;
    for (int i = 0; i < NV; i++) lbl_ok[i] = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_full_graph();
    test_backpressure();
    test_random_graphs();
    drain();
    repeat (50) @(posedge clk_i);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

### largest_connected_component_core.f
+incdir+rtl
rtl/lcc_pkg.sv
rtl/lcc_if.sv
rtl/lcc_ram.sv
rtl/largest_connected_component_core.sv
rtl/lcc_checker.sv
tb/sv/tb.sv
